// ----- rtl/kli_pkg.sv -----
// ----------------------------------------------------------------------------
// kli_pkg
// Shared constants, codes and types of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

   localparam int MAX_KEYS   = 16;
   localparam int KEY_W      = $clog2(MAX_KEYS);
   localparam int COUNT_W    = KEY_W + 1;
   localparam int NUM_CH     = 13;
   localparam int CH_W       = 4;
   localparam int VALUE_W    = 32;
   localparam int FRAME_W    = 16;
   localparam int VAL_DEPTH  = MAX_KEYS * NUM_CH;
   localparam int VAL_ADDR_W = $clog2(VAL_DEPTH);
   localparam int QUOT_W     = VALUE_W + 1;

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

   // item actions
   localparam logic [1:0] ACT_FRAME = 2'd0;
   localparam logic [1:0] ACT_VALUE = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RD_A,
      ST_RD_B,
      ST_START,
      ST_CALC,
      ST_EMIT
   } state_type;

   // key store access bundle
   typedef struct packed {
      logic                      frame_we;
      logic                      value_we;
      logic [KEY_W-1:0]          wr_key;
      logic [CH_W-1:0]           wr_chan;
      logic [FRAME_W-1:0]        wr_frame;
      logic signed [VALUE_W-1:0] wr_value;
      logic [KEY_W-1:0]          rd_frame_key;
      logic [KEY_W-1:0]          rd_key;
      logic [CH_W-1:0]           rd_chan;
   } store_req_type;

endpackage

`default_nettype wire

// ----- rtl/kli_key_store.sv -----
// ----------------------------------------------------------------------------
// kli_key_store
// Key frame memory and channel value memory, one write and one registered
// read each.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_key_store (
   input  wire                                  clock,
   input  kli_pkg::store_req_type               store_req,
   output logic [kli_pkg::FRAME_W-1:0]          rd_frame_ff,
   output logic signed [kli_pkg::VALUE_W-1:0]   rd_value_ff
);
   import kli_pkg::*;

   logic [FRAME_W-1:0]        frame_mem [MAX_KEYS];
   logic signed [VALUE_W-1:0] value_mem [VAL_DEPTH];
   logic [VAL_ADDR_W-1:0]     wr_addr;
   logic [VAL_ADDR_W-1:0]     rd_addr;

   // flatten key and channel into a value address
   assign wr_addr = VAL_ADDR_W'(store_req.wr_key) * VAL_ADDR_W'(NUM_CH)
                    + VAL_ADDR_W'(store_req.wr_chan);
   assign rd_addr = VAL_ADDR_W'(store_req.rd_key) * VAL_ADDR_W'(NUM_CH)
                    + VAL_ADDR_W'(store_req.rd_chan);

   always_ff @(posedge clock) begin
      if (store_req.frame_we) begin
         frame_mem[store_req.wr_key] <= store_req.wr_frame;
      end
      rd_frame_ff <= frame_mem[store_req.rd_frame_key];
   end

   always_ff @(posedge clock) begin
      if (store_req.value_we) begin
         value_mem[wr_addr] <= store_req.wr_value;
      end
      rd_value_ff <= value_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/kli_lerp_unit.sv -----
// ----------------------------------------------------------------------------
// kli_lerp_unit
// One interpolation: a + trunc((b - a) * t / span), saturated to 32 bits.
// Product is formed once, then a restoring divider retires one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_lerp_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire signed [kli_pkg::VALUE_W-1:0]    a,
   input  wire signed [kli_pkg::VALUE_W-1:0]    b,
   input  wire [kli_pkg::FRAME_W-1:0]           t,
   input  wire [kli_pkg::FRAME_W-1:0]           span,
   output logic                                 done_ff,
   output logic signed [kli_pkg::VALUE_W-1:0]   result_ff
);
   import kli_pkg::*;

   localparam int PROD_W = QUOT_W + FRAME_W + 1;
   localparam int MAG_W  = QUOT_W + FRAME_W - 1;
   localparam int SUM_W  = VALUE_W + 3;
   localparam int CNT_W  = $clog2(QUOT_W + 1);

   // clamp bounds of the signed output range
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

   logic signed [QUOT_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]         prod_abs;
   logic [FRAME_W:0]          rem_sh;
   logic                      rem_ge;
   logic signed [SUM_W-1:0]   q_ext;
   logic signed [SUM_W-1:0]   sum;
   logic signed [VALUE_W-1:0] sat;

   logic                      busy_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      neg_ff;
   logic [FRAME_W-1:0]        span_ff;
   logic [FRAME_W:0]          rem_ff;
   logic [QUOT_W-1:0]         quot_ff;
   logic signed [VALUE_W-1:0] base_ff;

   // product of the signed difference and the offset
   assign diff     = QUOT_W'(b) - QUOT_W'(a);
   assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
   assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

   // one restoring step
   assign rem_sh = {rem_ff[FRAME_W-1:0], quot_ff[QUOT_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, span_ff});

   // apply sign, add base, clamp
   assign q_ext = $signed({{(SUM_W-QUOT_W){1'b0}}, quot_ff});
   assign sum   = SUM_W'(base_ff) + (neg_ff ? -q_ext : q_ext);
   always_comb begin
      if (sum > SAT_HI) begin
         sat = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (sum < SAT_LO) begin
         sat = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat = sum[VALUE_W-1:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   // datapath; quotient fits QUOT_W bits since t < span
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= prod[PROD_W-1];
         span_ff <= span;
         base_ff <= a;
         rem_ff  <= {2'b00, prod_abs[MAG_W-1:QUOT_W]};
         quot_ff <= prod_abs[QUOT_W-1:0];
      end else if (busy_ff && count_ff != '0) begin
         rem_ff  <= rem_ge ? (rem_sh - {1'b0, span_ff}) : rem_sh;
         quot_ff <= {quot_ff[QUOT_W-2:0], rem_ge};
      end
      if (busy_ff && count_ff == '0) begin
         result_ff <= sat;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/keyframe_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Key table with per-channel linear interpolation between surrounding keys.
// ----------------------------------------------------------------------------
// Write beats (key frame, channel value) are taken while idle. A query scans
// the keys through the frame memory, a read state and a check state per key,
// then for each of the 13 channels reads the two key values and runs the
// shared bit-serial divider before the result beat is offered.
// A query that finds no bracketing pair answers with one not-found beat.
// The input channel stalls while a query is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_linear_interpolator (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire [1:0]                            req_action,
   input  wire [3:0]                            req_key_index,
   input  wire [3:0]                            req_channel,
   input  wire signed [31:0]                    req_value,
   input  wire [15:0]                           req_frame,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_found,
   output logic [3:0]                           rsp_out_channel,
   output logic signed [31:0]                   rsp_result_value,
   output logic [15:0]                          rsp_span,
   output logic                                 rsp_last,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [4:0]                            csr_key_count
);
   import kli_pkg::*;

   state_type            state_ff, state_in;
   store_req_type        store_req;
   logic [FRAME_W-1:0]   rd_frame;
   logic signed [VALUE_W-1:0] rd_value;
   logic                 lerp_start;
   logic                 lerp_done;
   logic signed [VALUE_W-1:0] lerp_result;
   logic                 req_beat;
   logic                 rsp_beat;
   logic                 past_end;
   logic                 key_after;

   logic [COUNT_W-1:0]   key_count_ff;
   logic [COUNT_W-1:0]   count_lim;
   logic [FRAME_W-1:0]   query_ff;
   logic [COUNT_W-1:0]   idx_ff;
   logic [KEY_W-1:0]     nxt_ff;
   logic [FRAME_W-1:0]   prev_frame_ff;
   logic [FRAME_W-1:0]   span_ff;
   logic [FRAME_W-1:0]   t_ff;
   logic [CH_W-1:0]      chan_ff;
   logic signed [VALUE_W-1:0] a_ff;
   logic                 found_ff;
   logic [CH_W-1:0]      out_chan_ff;
   logic signed [VALUE_W-1:0] result_ff;
   logic [FRAME_W-1:0]   out_span_ff;
   logic                 last_ff;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;
   assign count_lim = (key_count_ff > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS)
                                                          : key_count_ff;
   assign past_end  = (idx_ff == count_lim);
   assign key_after = (rd_frame > query_ff);

   // key count register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         key_count_ff <= csr_key_count;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_action == ACT_QUERY) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = past_end ? ST_EMIT : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!key_after) state_in = ST_SCAN_RD;
            else if (idx_ff == '0) state_in = ST_EMIT;
            else state_in = ST_RD_A;
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_START;
         ST_START: state_in = ST_CALC;
         ST_CALC: begin
            if (lerp_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_beat) state_in = last_ff ? ST_IDLE : ST_RD_A;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // state outputs and store access
   always_comb begin
      req_stall              = (state_ff != ST_IDLE);
      rsp_valid              = (state_ff == ST_EMIT);
      lerp_start             = (state_ff == ST_START);
      store_req.frame_we     = (state_ff == ST_IDLE) && req_valid
                               && req_action == ACT_FRAME;
      store_req.value_we     = (state_ff == ST_IDLE) && req_valid
                               && req_action == ACT_VALUE
                               && req_channel <= LAST_CH;
      store_req.wr_key       = req_key_index;
      store_req.wr_chan      = req_channel;
      store_req.wr_frame     = req_frame;
      store_req.wr_value     = req_value;
      store_req.rd_frame_key = idx_ff[KEY_W-1:0];
      store_req.rd_key       = (state_ff == ST_RD_A) ? nxt_ff - 1'b1 : nxt_ff;
      store_req.rd_chan      = chan_ff;
   end

   // query datapath and result register
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            query_ff <= req_frame;
            idx_ff   <= '0;
         end
         ST_SCAN_RD: begin
            if (past_end) begin
               found_ff    <= 1'b0;
               out_chan_ff <= '0;
               result_ff   <= '0;
               out_span_ff <= '0;
               last_ff     <= 1'b1;
            end
         end
         ST_SCAN_CHK: begin
            if (!key_after) begin
               prev_frame_ff <= rd_frame;
               idx_ff        <= idx_ff + 1'b1;
            end else if (idx_ff == '0) begin
               found_ff    <= 1'b0;
               out_chan_ff <= '0;
               result_ff   <= '0;
               out_span_ff <= '0;
               last_ff     <= 1'b1;
            end else begin
               nxt_ff  <= idx_ff[KEY_W-1:0];
               span_ff <= rd_frame - prev_frame_ff;
               t_ff    <= query_ff - prev_frame_ff;
               chan_ff <= '0;
            end
         end
         ST_RD_B: begin
            a_ff <= rd_value;
         end
         ST_CALC: begin
            if (lerp_done) begin
               found_ff    <= 1'b1;
               out_chan_ff <= chan_ff;
               result_ff   <= lerp_result;
               out_span_ff <= span_ff;
               last_ff     <= (chan_ff == LAST_CH);
            end
         end
         ST_EMIT: begin
            if (rsp_beat) chan_ff <= chan_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_found        = found_ff;
   assign rsp_out_channel  = out_chan_ff;
   assign rsp_result_value = result_ff;
   assign rsp_span         = out_span_ff;
   assign rsp_last         = last_ff;

   kli_key_store u_store (
      .clock       (clock),
      .store_req   (store_req),
      .rd_frame_ff (rd_frame),
      .rd_value_ff (rd_value)
   );

   kli_lerp_unit u_lerp (
      .clock     (clock),
      .reset     (reset),
      .start     (lerp_start),
      .a         (a_ff),
      .b         (rd_value),
      .t         (t_ff),
      .span      (span_ff),
      .done_ff   (lerp_done),
      .result_ff (lerp_result)
   );

endmodule

`default_nettype wire

// ----- rtl/kli_checker.sv -----
// ----------------------------------------------------------------------------
// kli_checker
// Port-level checks on the result channel of the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_found,
   input wire [3:0]  rsp_out_channel,
   input wire [31:0] rsp_result_value,
   input wire [15:0] rsp_span,
   input wire        rsp_last
);

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("rsp beat changed while stalled");

   // not-found beat is a lone, zeroed, final beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_span == 16'd0
         && rsp_result_value == 32'd0 && rsp_out_channel == 4'd0)
      else $error("malformed not-found beat");

   // a bracketing pair always has a positive span
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_span != 16'd0)
      else $error("zero span on found beat");

   // final found beat carries the last channel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_last == (rsp_out_channel == 4'd12)))
      else $error("last flag out of step with channel");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_out_channel  (rsp_out_channel),
   .rsp_result_value (rsp_result_value),
   .rsp_span         (rsp_span),
   .rsp_last         (rsp_last)
);

`default_nettype wire
